// ===== rtl/glos_pkg.sv =====
`timescale 1ns / 1ps

package glos_pkg;

    // Widths fixed by the item fields and by the arithmetic on them.
    localparam int COORD_W = 6;
    localparam int NUM_W   = 16;
    localparam int DEN_W   = 7;
    localparam int STEP_W  = 8;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [COORD_W-1:0]      t_coord;
    typedef logic signed [NUM_W-1:0] t_num;
    typedef logic [DEN_W-1:0]        t_den;

    typedef struct packed {
        logic start;
        t_num num;
        t_den den;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_num quo;
        t_den rem;
    } t_div_rsp;

endpackage

// ===== rtl/glos_ram.sv =====
`timescale 1ns / 1ps

module glos_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/glos_div.sv =====
`timescale 1ns / 1ps

// Floor division of a signed numerator by a positive denominator, one
// quotient bit per cycle, with the remainder kept in [0, den).
module glos_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  glos_pkg::t_div_req i_req,
    output glos_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(glos_pkg::NUM_W + 1);

    logic                        r_busy, n_busy;
    logic                        r_fin, n_fin;
    logic                        r_done, n_done;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        r_neg, n_neg;
    logic [glos_pkg::NUM_W-1:0]  r_mag, n_mag;
    glos_pkg::t_den              r_rem, n_rem;
    glos_pkg::t_den              r_den, n_den;
    glos_pkg::t_num              r_quo, n_quo;
    glos_pkg::t_den              r_rq, n_rq;
    logic [glos_pkg::DEN_W:0]    w_trial;

    always_comb begin
        n_busy = r_busy;
        n_fin  = 1'b0;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_mag  = r_mag;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        n_rq   = r_rq;
        w_trial = {r_rem, r_mag[glos_pkg::NUM_W-1]};

        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_neg  = i_req.num[glos_pkg::NUM_W-1];
            n_mag  = i_req.num[glos_pkg::NUM_W-1] ? glos_pkg::NUM_W'(-i_req.num)
                                                   : glos_pkg::NUM_W'(i_req.num);
            n_rem  = '0;
            n_den  = i_req.den;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = glos_pkg::DEN_W'(w_trial - {1'b0, r_den});
                n_mag = {r_mag[glos_pkg::NUM_W-2:0], 1'b1};
            end else begin
                n_rem = glos_pkg::DEN_W'(w_trial);
                n_mag = {r_mag[glos_pkg::NUM_W-2:0], 1'b0};
            end
            n_cnt = CNT_W'(r_cnt + 1'b1);
            if (r_cnt == CNT_W'(glos_pkg::NUM_W - 1)) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end

        // Turn the truncated magnitude result into a floor result.
        if (r_fin) begin
            n_done = 1'b1;
            if (r_neg && (r_rem != '0)) begin
                n_quo = glos_pkg::t_num'(~r_mag);
                n_rq  = r_den - r_rem;
            end else if (r_neg) begin
                n_quo = glos_pkg::t_num'(~r_mag + glos_pkg::NUM_W'(1));
                n_rq  = '0;
            end else begin
                n_quo = glos_pkg::t_num'(r_mag);
                n_rq  = r_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_mag <= n_mag;
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
        r_rq  <= n_rq;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rq;

endmodule

// ===== rtl/grid_line_of_sight_check.sv =====
// Write item: accepted from idle, then a read-modify-write of one column word.
// Query item: setup, then two floor divisions on the shared serial divider, then a
// walk over the columns from min x to max x, then drain and deliver; a vertical
// segment skips the divisions. One item at a time.
// Reset is synchronous and active low; afterwards a clearing pass writes every column
// word to open, during which no item is accepted.
`timescale 1ns / 1ps

// The bitmap is held column by column: one memory word per column x, one bit per
// row y. A query then needs one memory read per column, and the rows that the line
// covers in that column are checked all at once against a row range mask.
//
// The line's y at each column boundary x - 1/2 is tracked as an exact fraction
// n / den with den = 2|dx|. The divider produces floor(n0 / den) for the first
// boundary and floor(step / den) for the per-column step; after that each column
// costs one add, one compare and a remainder correction.
//
// Items are handled one at a time, so a memory write always lands before the next
// read of any column; no forwarding is needed.
module grid_line_of_sight_check #(
    parameter int GRID_WIDTH  = glos_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = glos_pkg::GRID_HEIGHT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_op,
    input  logic [glos_pkg::COORD_W-1:0] i_cell_x,
    input  logic [glos_pkg::COORD_W-1:0] i_cell_y,
    input  logic                    i_blocked,
    input  logic [glos_pkg::COORD_W-1:0] i_start_x,
    input  logic [glos_pkg::COORD_W-1:0] i_start_y,
    input  logic [glos_pkg::COORD_W-1:0] i_end_x,
    input  logic [glos_pkg::COORD_W-1:0] i_end_y,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_visible
);

    localparam int AW     = $clog2(GRID_WIDTH);
    localparam int CW     = glos_pkg::COORD_W;
    localparam int DW     = glos_pkg::DEN_W;
    localparam int STEP_W = glos_pkg::STEP_W;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_MOD,
        ST_PREP,
        ST_DIVA_GO,
        ST_DIVA_WAIT,
        ST_DIVB_GO,
        ST_DIVB_WAIT,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Control registers.
    t_state            r_state, n_state;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic              r_p_valid, n_p_valid;
    logic              r_out_valid, n_out_valid;

    // Payload registers.
    logic              r_out_vis, n_out_vis;
    logic [AW-1:0]     r_wr_x, n_wr_x;
    glos_pkg::t_coord  r_wr_y, n_wr_y;
    logic              r_wr_bit, n_wr_bit;
    glos_pkg::t_coord  r_x1, n_x1, r_y1, n_y1, r_x2, n_x2, r_y2, n_y2;
    glos_pkg::t_coord  r_xhi, n_xhi, r_ylo, n_ylo, r_yhi, n_yhi;
    glos_pkg::t_coord  r_xcur, n_xcur;
    logic              r_vert, n_vert;
    glos_pkg::t_den    r_den, n_den;
    logic signed [STEP_W-1:0] r_step, n_step;
    glos_pkg::t_num    r_n0, n_n0;
    glos_pkg::t_num    r_q, n_q, r_sq, n_sq;
    glos_pkg::t_den    r_r, n_r, r_sr, n_sr;
    logic              r_ok, n_ok;
    glos_pkg::t_coord  r_p_rlo, n_p_rlo, r_p_rhi, n_p_rhi;
    logic              r_p_empty, n_p_empty;
    logic              r_p_xoob, n_p_xoob;

    // Memory port signals.
    logic                   w_ram_wr_en, w_ram_rd_en;
    logic [AW-1:0]          w_ram_wr_addr, w_ram_rd_addr;
    logic [GRID_HEIGHT-1:0] w_ram_wr_data, w_ram_rd_data, w_mod_data;

    glos_pkg::t_div_req w_div_req;
    glos_pkg::t_div_rsp w_div_rsp;

    // Segment setup.
    logic signed [CW:0]     w_dx, w_dy, w_sdy;
    logic                   w_neg;
    glos_pkg::t_coord       w_adx, w_xlo;
    logic signed [STEP_W-1:0] w_toff;

    // Column walk.
    logic [DW:0]            w_sum;
    logic                   w_carry;
    glos_pkg::t_den         w_rn;
    glos_pkg::t_num         w_qn, w_fl, w_ce, w_rlo, w_rhi, w_ylo_n, w_yhi_n;
    logic                   w_xoob;

    // Column check.
    logic                   w_hit, w_yoob, w_blk;
    logic                   w_accept, w_wr_ingrid;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_wr_ingrid = (int'(i_cell_x) < GRID_WIDTH) && (int'(i_cell_y) < GRID_HEIGHT);

    glos_ram #(
        .WIDTH (GRID_HEIGHT),
        .DEPTH (GRID_WIDTH)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr_en),
        .i_wr_addr (w_ram_wr_addr),
        .i_wr_data (w_ram_wr_data),
        .i_rd_en   (w_ram_rd_en),
        .i_rd_addr (w_ram_rd_addr),
        .o_rd_data (w_ram_rd_data)
    );

    glos_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Segment setup arithmetic, used in the PREP state. With dx negative the
    // fraction is negated so that the denominator stays positive.
    always_comb begin
        w_dx   = $signed({1'b0, r_x2}) - $signed({1'b0, r_x1});
        w_dy   = $signed({1'b0, r_y2}) - $signed({1'b0, r_y1});
        w_neg  = w_dx[CW];
        w_adx  = w_neg ? CW'(-w_dx) : CW'(w_dx);
        w_sdy  = w_neg ? -w_dy : w_dy;
        w_xlo  = w_neg ? r_x2 : r_x1;
        w_toff = $signed({1'b0, w_xlo, 1'b0}) - $signed({1'b0, r_x1, 1'b0})
                 - STEP_W'(1);
    end

    // One column step of the boundary fraction, and the row range it gives.
    always_comb begin
        w_sum   = {1'b0, r_r} + {1'b0, r_sr};
        w_carry = (w_sum >= {1'b0, r_den});
        w_rn    = w_carry ? DW'(w_sum - {1'b0, r_den}) : DW'(w_sum);
        w_qn    = r_q + r_sq + glos_pkg::t_num'(w_carry);
        // A rising line has its low end at the left boundary of the column.
        if (r_step[STEP_W-1]) begin
            w_fl = w_qn;
            w_ce = r_q + glos_pkg::t_num'(r_r != '0);
        end else begin
            w_fl = r_q;
            w_ce = w_qn + glos_pkg::t_num'(w_rn != '0);
        end
        w_ylo_n = glos_pkg::t_num'(r_ylo);
        w_yhi_n = glos_pkg::t_num'(r_yhi);
        if (r_vert) begin
            w_rlo = w_ylo_n;
            w_rhi = w_yhi_n;
        end else begin
            w_rlo = (w_fl > w_ylo_n) ? w_fl : w_ylo_n;
            w_rhi = (w_ce < w_yhi_n) ? w_ce : w_yhi_n;
        end
        w_xoob = (int'(r_xcur) >= GRID_WIDTH);
    end

    // Check of the column word read in the previous cycle. Cells off the grid
    // count as blocked.
    always_comb begin
        w_hit = 1'b0;
        for (int i = 0; i < GRID_HEIGHT; i++) begin
            if (w_ram_rd_data[i] && (i >= int'(r_p_rlo)) && (i <= int'(r_p_rhi))) begin
                w_hit = 1'b1;
            end
        end
        w_yoob = (int'(r_p_rhi) >= GRID_HEIGHT);
        w_blk  = !r_p_empty && (r_p_xoob || w_yoob || w_hit);
        for (int i = 0; i < GRID_HEIGHT; i++) begin
            w_mod_data[i] = (i == int'(r_wr_y)) ? r_wr_bit : w_ram_rd_data[i];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_p_valid   = 1'b0;
        n_out_valid = r_out_valid;
        n_out_vis   = r_out_vis;
        n_wr_x      = r_wr_x;
        n_wr_y      = r_wr_y;
        n_wr_bit    = r_wr_bit;
        n_x1        = r_x1;
        n_y1        = r_y1;
        n_x2        = r_x2;
        n_y2        = r_y2;
        n_xhi       = r_xhi;
        n_ylo       = r_ylo;
        n_yhi       = r_yhi;
        n_xcur      = r_xcur;
        n_vert      = r_vert;
        n_den       = r_den;
        n_step      = r_step;
        n_n0        = r_n0;
        n_q         = r_q;
        n_r         = r_r;
        n_sq        = r_sq;
        n_sr        = r_sr;
        n_ok        = r_p_valid ? (r_ok && !w_blk) : r_ok;
        n_p_rlo     = r_p_rlo;
        n_p_rhi     = r_p_rhi;
        n_p_empty   = r_p_empty;
        n_p_xoob    = r_p_xoob;

        w_ram_wr_en   = 1'b0;
        w_ram_wr_addr = r_wr_x;
        w_ram_wr_data = w_mod_data;
        w_ram_rd_en   = 1'b0;
        w_ram_rd_addr = w_xoob ? '0 : AW'(r_xcur);

        w_div_req.start = 1'b0;
        w_div_req.num   = r_n0;
        w_div_req.den   = r_den;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                w_ram_wr_en   = 1'b1;
                w_ram_wr_addr = r_clr_addr;
                w_ram_wr_data = '0;
                n_clr_addr    = AW'(r_clr_addr + 1'b1);
                if (r_clr_addr == AW'(GRID_WIDTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_op == glos_pkg::OP_QUERY) begin
                        n_x1    = i_start_x;
                        n_y1    = i_start_y;
                        n_x2    = i_end_x;
                        n_y2    = i_end_y;
                        n_state = ST_PREP;
                    end else if (i_op == glos_pkg::OP_WRITE && w_wr_ingrid) begin
                        w_ram_rd_en   = 1'b1;
                        w_ram_rd_addr = AW'(i_cell_x);
                        n_wr_x        = AW'(i_cell_x);
                        n_wr_y        = i_cell_y;
                        n_wr_bit      = i_blocked;
                        n_state       = ST_WR_MOD;
                    end
                end
            end
            ST_WR_MOD: begin
                w_ram_wr_en = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_PREP: begin
                n_vert = (w_dx == '0);
                n_den  = DW'({w_adx, 1'b0});
                n_step = $signed({w_sdy, 1'b0});
                n_n0   = glos_pkg::t_num'({r_y1, 1'b0}) * glos_pkg::t_num'(w_adx)
                         + glos_pkg::t_num'(w_sdy) * glos_pkg::t_num'(w_toff);
                n_xcur = w_xlo;
                n_xhi  = w_neg ? r_x1 : r_x2;
                n_ylo  = (r_y1 < r_y2) ? r_y1 : r_y2;
                n_yhi  = (r_y1 < r_y2) ? r_y2 : r_y1;
                n_ok   = 1'b1;
                n_state = (w_dx == '0) ? ST_WALK : ST_DIVA_GO;
            end
            ST_DIVA_GO: begin
                w_div_req.start = 1'b1;
                n_state         = ST_DIVA_WAIT;
            end
            ST_DIVA_WAIT: begin
                if (w_div_rsp.done) begin
                    n_q     = w_div_rsp.quo;
                    n_r     = w_div_rsp.rem;
                    n_state = ST_DIVB_GO;
                end
            end
            ST_DIVB_GO: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = glos_pkg::t_num'(r_step);
                n_state         = ST_DIVB_WAIT;
            end
            ST_DIVB_WAIT: begin
                if (w_div_rsp.done) begin
                    n_sq    = w_div_rsp.quo;
                    n_sr    = w_div_rsp.rem;
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                w_ram_rd_en = 1'b1;
                n_p_valid   = 1'b1;
                n_p_rlo     = CW'(w_rlo);
                n_p_rhi     = CW'(w_rhi);
                n_p_empty   = (w_rlo > w_rhi);
                n_p_xoob    = w_xoob;
                n_q         = w_qn;
                n_r         = w_rn;
                n_xcur      = CW'(r_xcur + 1'b1);
                if (r_xcur == r_xhi) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_vis   = r_ok;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out_vis <= n_out_vis;
        r_wr_x    <= n_wr_x;
        r_wr_y    <= n_wr_y;
        r_wr_bit  <= n_wr_bit;
        r_x1      <= n_x1;
        r_y1      <= n_y1;
        r_x2      <= n_x2;
        r_y2      <= n_y2;
        r_xhi     <= n_xhi;
        r_ylo     <= n_ylo;
        r_yhi     <= n_yhi;
        r_xcur    <= n_xcur;
        r_vert    <= n_vert;
        r_den     <= n_den;
        r_step    <= n_step;
        r_n0      <= n_n0;
        r_q       <= n_q;
        r_r       <= n_r;
        r_sq      <= n_sq;
        r_sr      <= n_sr;
        r_ok      <= n_ok;
        r_p_rlo   <= n_p_rlo;
        r_p_rhi   <= n_p_rhi;
        r_p_empty <= n_p_empty;
        r_p_xoob  <= n_p_xoob;
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_p_valid   <= n_p_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_visible   = r_out_vis;

`ifndef SYNTHESIS
    // The single memory port pair is never asked to read and write in one cycle.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_wr_en |-> !w_ram_rd_en)
        else $error("memory read and write in the same cycle");

    // A column check only follows a column read of the walk.
    a_check_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> $past(r_state) == ST_WALK)
        else $error("column check without a preceding column read");

    // Divider results only arrive while the sequencer waits for them.
    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ST_DIVA_WAIT || r_state == ST_DIVB_WAIT))
        else $error("divider result outside a wait state");

    // The boundary remainder stays reduced during a sloped walk.
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && !r_vert) |-> (r_r < r_den))
        else $error("boundary remainder not below denominator");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Checks the grid line of sight block: random cell writes build up a map of
// blocked cells, and queries ask whether a segment between two cells passes only
// open cells. The testbench keeps its own map of the grid and walks the segment
// with exact rational arithmetic to work out the expected visible bit.
module tb;

    localparam int GW = 64;
    localparam int GH = 64;

    // Holds the expected visible bits, in order, and counts mismatches.
    class sight_scoreboard;
        bit pending_vis[$];
        int errors;

        function void note_query(bit vis);
            pending_vis.insert(pending_vis.size(), vis);
        endfunction

        function void check_result(bit got);
            bit want;
            if (pending_vis.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result visible=%0d", got);
            end else begin
                want = pending_vis.pop_front();
                if (want != got) begin
                    errors++;
                    if (errors <= 10)
                        $display("visible mismatch: expected %0d, got %0d", want, got);
                end
            end
        endfunction
    endclass

    logic       i_clk, i_rst_n;
    logic       i_in_valid, o_in_stall;
    logic       i_op;
    glos_pkg::t_coord i_cell_x, i_cell_y, i_start_x, i_start_y, i_end_x, i_end_y;
    logic       i_blocked;
    logic       o_out_valid, i_out_stall, o_visible;

    grid_line_of_sight_check dut (.*);

    sight_scoreboard sb;
    bit grid_map [GW*GH];
    bit sending_done;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit cell_is_open(int x, int y);
        if (x < 0 || y < 0 || x >= GW || y >= GH) return 0;
        return !grid_map[y*GW + x];
    endfunction

    // Floor and ceiling of n / d for positive d, exact.
    function automatic int div_floor(int n, int d);
        int q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic int div_ceil(int n, int d);
        int q;
        q = n / d;
        if ((n % d) != 0 && n > 0) q++;
        return q;
    endfunction

    // For each column the rows covered by the line over [x - 1/2, x + 1/2] are
    // taken, clipped to the segment's row span; a vertical segment is its column.
    function automatic bit predict_visible(int x1, int y1, int x2, int y2);
        int xlo, xhi, ylo, yhi, dx, dy, den, na, nb, rlo, rhi, t;
        xlo = (x1 < x2) ? x1 : x2;
        xhi = (x1 < x2) ? x2 : x1;
        ylo = (y1 < y2) ? y1 : y2;
        yhi = (y1 < y2) ? y2 : y1;
        dx = x2 - x1;
        dy = y2 - y1;
        if (dx == 0) begin
            for (int y = ylo; y <= yhi; y++)
                if (!cell_is_open(x1, y)) return 0;
            return 1;
        end
        for (int x = xlo; x <= xhi; x++) begin
            den = 2*dx;
            na = 2*y1*dx + dy*(2*x - 1 - 2*x1);
            nb = 2*y1*dx + dy*(2*x + 1 - 2*x1);
            if (den < 0) begin
                den = -den; na = -na; nb = -nb;
            end
            if (na > nb) begin
                t = na; na = nb; nb = t;
            end
            rlo = div_floor(na, den);
            rhi = div_ceil(nb, den);
            if (rlo < ylo) rlo = ylo;
            if (rhi > yhi) rhi = yhi;
            for (int y = rlo; y <= rhi; y++)
                if (!cell_is_open(x, y)) return 0;
        end
        return 1;
    endfunction

    // Presents one item, holds it until accepted, then updates the prediction.
    task automatic send_item(bit op, int cx, int cy, bit blk, int sx, int sy,
                             int ex, int ey);
        i_in_valid <= 1;
        i_op <= op;
        i_cell_x <= glos_pkg::t_coord'(cx);
        i_cell_y <= glos_pkg::t_coord'(cy);
        i_blocked <= blk;
        i_start_x <= glos_pkg::t_coord'(sx);
        i_start_y <= glos_pkg::t_coord'(sy);
        i_end_x <= glos_pkg::t_coord'(ex);
        i_end_y <= glos_pkg::t_coord'(ey);
        do @(posedge i_clk); while (o_in_stall);
        if (op == glos_pkg::OP_WRITE) grid_map[cy*GW + cx] = blk;
        else sb.note_query(predict_visible(sx, sy, ex, ey));
        @(negedge i_clk);
    endtask

    task automatic send_write(int cx, int cy, bit blk);
        send_item(glos_pkg::OP_WRITE, cx, cy, blk, $urandom, $urandom, $urandom,
                  $urandom);
    endtask

    task automatic send_query(int sx, int sy, int ex, int ey);
        send_item(glos_pkg::OP_QUERY, $urandom, $urandom, $urandom, sx, sy, ex, ey);
    endtask

    task automatic idle_gap();
        i_in_valid <= 0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    // Random traffic: random blocked cells along with lots of clearing keep the
    // map partly open so both visible values come up often.
    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) send_write($urandom_range(0, 63), $urandom_range(0, 63),
                               $urandom_range(0, 99) < 30);
        else if (r < 55) send_query($urandom_range(0, 63), $urandom_range(0, 63),
                                    $urandom_range(0, 63), $urandom_range(0, 63));
        else if (r < 65) begin
            r = $urandom_range(0, 63);
            send_query(r, $urandom_range(0, 63), r, $urandom_range(0, 63));
        end else begin
            // Short segments stay in small regions and are often visible.
            int sx, sy;
            sx = $urandom_range(0, 63);
            sy = $urandom_range(0, 63);
            send_query(sx, sy, $urandom_range(sx > 6 ? sx-6 : 0, sx < 57 ? sx+6 : 63),
                       $urandom_range(sy > 6 ? sy-6 : 0, sy < 57 ? sy+6 : 63));
        end
    endtask

    // The receiver stalls in modes: none, light random, heavy random.
    initial begin
        int mode;
        i_out_stall = 0;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 400)) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_stall <= 0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    default: i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_visible);

    initial begin
        int burst;
        sb = new();
        sending_done = 0;
        i_rst_n = 0; i_in_valid = 0; i_op = 0; i_blocked = 0;
        i_cell_x = 0; i_cell_y = 0; i_start_x = 0; i_start_y = 0;
        i_end_x = 0; i_end_y = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed part: empty-map extremes, then a blocked corner and full spans.
        send_query(0, 0, 63, 63);
        send_query(63, 0, 0, 63);
        send_query(5, 5, 5, 5);
        send_write(63, 63, 1);
        send_query(0, 0, 63, 63);
        send_query(63, 63, 63, 63);
        send_query(63, 0, 63, 63);
        send_query(0, 63, 62, 63);
        send_write(63, 63, 0);
        send_query(0, 0, 63, 63);
        send_write(0, 0, 1);
        send_query(0, 0, 0, 0);
        send_query(63, 0, 0, 0);
        send_write(0, 0, 0);
        send_write(32, 1, 1);
        send_query(0, 0, 63, 2);
        send_query(0, 2, 63, 0);
        send_query(31, 0, 33, 0);
        send_query(32, 63, 32, 0);
        send_write(32, 1, 0);
        send_query(0, 1, 63, 1);

        repeat (1330) begin
            burst = $urandom_range(0, 3);
            if (burst == 0) idle_gap();
            random_item();
        end
        i_in_valid <= 0;

        while (sb.pending_vis.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    // Time limit for the slowest run: about 1350 items, plus stalls and gaps.
    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule
